[src/csrp_pkg.sv]
// Shared types, constants and helper functions for the character-set spec range parser.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package csrp_pkg;

  localparam int CODE_BITS = 21;
  localparam int POS_BITS  = 16;

  // Result queue sizing
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  localparam logic [7:0] CH_DASH = 8'h2D;
  localparam logic [7:0] CH_BSL  = 8'h5C;
  localparam logic [7:0] CH_LC_U = 8'h75;
  localparam logic [7:0] CH_0    = 8'h30;
  localparam logic [7:0] CH_9    = 8'h39;
  localparam logic [7:0] CH_UC_A = 8'h41;
  localparam logic [7:0] CH_UC_F = 8'h46;
  localparam logic [7:0] CH_UC_Z = 8'h5A;
  localparam logic [7:0] CH_LC_A = 8'h61;
  localparam logic [7:0] CH_LC_F = 8'h66;
  localparam logic [7:0] CH_LC_Z = 8'h7A;

  localparam logic [2:0] ERR_BAD_CHAR   = 3'd0;
  localparam logic [2:0] ERR_NO_UPPER   = 3'd1;
  localparam logic [2:0] ERR_GROUP      = 3'd2;
  localparam logic [2:0] ERR_LOW_HIGH   = 3'd3;
  localparam logic [2:0] ERR_ESC_SYNTAX = 3'd4;

  localparam logic [1:0] GRP_NONE  = 2'd0;
  localparam logic [1:0] GRP_DIGIT = 2'd1;
  localparam logic [1:0] GRP_UPPER = 2'd2;
  localparam logic [1:0] GRP_LOWER = 2'd3;

  typedef struct packed {
    logic                 ok;
    logic [3:0]           val;
  } hex_t;

  typedef struct packed {
    logic                 range_valid;
    logic [CODE_BITS-1:0] range_low;
    logic [CODE_BITS-1:0] range_high;
    logic                 error_valid;
    logic [2:0]           error_code;
    logic [POS_BITS-1:0]  error_pos;
    logic                 spec_done;
  } result_t;

  // Up to two results produced by one byte
  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } push_t;

  function automatic logic [1:0] group_of(input logic [7:0] c);
    logic [1:0] g;
    g = GRP_NONE;
    if (c >= CH_0 && c <= CH_9) g = GRP_DIGIT;
    else if (c >= CH_UC_A && c <= CH_UC_Z) g = GRP_UPPER;
    else if (c >= CH_LC_A && c <= CH_LC_Z) g = GRP_LOWER;
    return g;
  endfunction

  function automatic hex_t hex_of(input logic [7:0] c);
    hex_t       h;
    logic [7:0] v;
    h = '0;
    v = '0;
    if (c >= CH_0 && c <= CH_9) begin
      v = c - CH_0;
      h.ok = 1'b1;
    end else if (c >= CH_UC_A && c <= CH_UC_F) begin
      v = c - CH_UC_A + 8'd10;
      h.ok = 1'b1;
    end else if (c >= CH_LC_A && c <= CH_LC_F) begin
      v = c - CH_LC_A + 8'd10;
      h.ok = 1'b1;
    end
    h.val = v[3:0];
    return h;
  endfunction

  function automatic result_t mk_range(input logic [CODE_BITS-1:0] lo,
                                       input logic [CODE_BITS-1:0] hi);
    result_t r;
    r = '0;
    r.range_valid = 1'b1;
    r.range_low   = lo;
    r.range_high  = hi;
    return r;
  endfunction

  function automatic result_t mk_error(input logic [2:0] code,
                                       input logic [POS_BITS-1:0] pos);
    result_t r;
    r = '0;
    r.error_valid = 1'b1;
    r.error_code  = code;
    r.error_pos   = pos;
    return r;
  endfunction

endpackage

[src/charset_spec_range_parser.sv]
// Path: an accepted byte is held in the input word register until the queue has room; its
//   results are then written into the result queue, from which the output channel takes them.
// Throughput: one byte per cycle; the input stalls while more than two results wait.
// Reset (rst, synchronous): clears the parse state, the byte offset and the queue.
// Top level of the character-set spec range parser; depends on csrp_pkg,
//   csrp_parser and csrp_result_queue.
`timescale 1ns / 1ps

module charset_spec_range_parser import csrp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [7:0]           spec_byte,
  input  logic                 final_byte,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 range_valid,
  output logic [CODE_BITS-1:0] range_low,
  output logic [CODE_BITS-1:0] range_high,
  output logic                 error_valid,
  output logic [2:0]           error_code,
  output logic [POS_BITS-1:0]  error_pos,
  output logic                 spec_done
);

  push_t   push;
  logic    room;
  result_t out_word;

  csrp_parser u_parser (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .spec_byte  (spec_byte),
    .final_byte (final_byte),
    .room       (room),
    .push       (push)
  );

  csrp_result_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  assign range_valid = out_word.range_valid;
  assign range_low   = out_word.range_low;
  assign range_high  = out_word.range_high;
  assign error_valid = out_word.error_valid;
  assign error_code  = out_word.error_code;
  assign error_pos   = out_word.error_pos;
  assign spec_done   = out_word.spec_done;

endmodule

[src/csrp_parser.sv]
// Input word register, parse state and the single-pass per-byte step logic.
// Depends on csrp_pkg; feeds up to two results per byte into csrp_result_queue.
`timescale 1ns / 1ps

module csrp_parser import csrp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] spec_byte,
  input  logic       final_byte,
  input  logic       room,
  output push_t      push
);

  localparam logic [2:0] PH_IDLE     = 3'd0;
  localparam logic [2:0] PH_HELD     = 3'd1;
  localparam logic [2:0] PH_DASH     = 3'd2;
  localparam logic [2:0] PH_ESC_FROM = 3'd3;
  localparam logic [2:0] PH_ESC_BSL  = 3'd4;
  localparam logic [2:0] PH_ESC_U    = 3'd5;
  localparam logic [2:0] PH_ESC_TO   = 3'd6;

  logic                 in_full;
  logic [7:0]           byte_q;
  logic                 fin_q;
  logic                 advance;

  logic [2:0]           phase, phase_next;
  logic [7:0]           held, held_next;
  logic [CODE_BITS-1:0] esc_from, from_next;
  logic [CODE_BITS-1:0] esc_to, to_next;
  logic                 ovf, ovf_next;
  logic                 digit_seen, digit_next;
  logic [POS_BITS-1:0]  esc_pos, epos_next;
  logic [POS_BITS-1:0]  pos;
  logic                 err, err_next;

  logic [POS_BITS-1:0]  pos_inc;
  hex_t                 hx;
  logic                 body_hit, fin_hit;
  result_t              body_res, fin_res;
  logic                 close_fail, close_emit;

  assign advance  = in_full && room;
  assign in_stall = in_full && !room;
  assign pos_inc  = pos + POS_BITS'(1);
  assign hx       = hex_of(byte_q);

  // Escape close at the last byte uses the post-body values.
  assign close_fail = !digit_next || ovf_next;
  assign close_emit = !close_fail && (from_next <= to_next);

  always_comb begin
    phase_next = phase;
    held_next  = held;
    from_next  = esc_from;
    to_next    = esc_to;
    ovf_next   = ovf;
    digit_next = digit_seen;
    epos_next  = esc_pos;
    err_next   = err;
    body_hit   = 1'b0;
    body_res   = '0;

    if (!err) begin
      unique case (phase)
        PH_HELD: begin
          if (byte_q == CH_DASH) begin
            if (group_of(held) == GRP_NONE) begin
              body_hit = 1'b1;
              body_res = mk_error(ERR_BAD_CHAR, pos);
              err_next = 1'b1;
            end else begin
              phase_next = PH_DASH;
            end
          end else if (held == CH_BSL && byte_q == CH_LC_U) begin
            phase_next = PH_ESC_FROM;
            epos_next  = pos_inc;
            from_next  = '0;
            to_next    = '0;
            ovf_next   = 1'b0;
            digit_next = 1'b0;
          end else begin
            body_hit  = 1'b1;
            body_res  = mk_range(CODE_BITS'(held), CODE_BITS'(held));
            held_next = byte_q;
          end
        end
        PH_DASH: begin
          if (group_of(byte_q) != group_of(held)) begin
            body_hit = 1'b1;
            body_res = mk_error(ERR_GROUP, pos);
            err_next = 1'b1;
          end else if (byte_q < held) begin
            body_hit = 1'b1;
            body_res = mk_error(ERR_LOW_HIGH, pos);
            err_next = 1'b1;
          end else begin
            body_hit   = 1'b1;
            body_res   = mk_range(CODE_BITS'(held), CODE_BITS'(byte_q));
            phase_next = PH_IDLE;
          end
        end
        PH_ESC_FROM: begin
          if (hx.ok) begin
            if (esc_from[CODE_BITS-1 -: 4] != 4'd0) ovf_next = 1'b1;
            from_next  = {esc_from[CODE_BITS-5:0], hx.val};
            digit_next = 1'b1;
          end else if (byte_q == CH_DASH && digit_seen) begin
            phase_next = PH_ESC_BSL;
          end else begin
            body_hit = 1'b1;
            body_res = mk_error(ERR_ESC_SYNTAX, esc_pos);
            err_next = 1'b1;
          end
        end
        PH_ESC_BSL: begin
          if (byte_q == CH_BSL) begin
            phase_next = PH_ESC_U;
          end else begin
            body_hit = 1'b1;
            body_res = mk_error(ERR_ESC_SYNTAX, esc_pos);
            err_next = 1'b1;
          end
        end
        PH_ESC_U: begin
          if (byte_q == CH_LC_U) begin
            phase_next = PH_ESC_TO;
            digit_next = 1'b0;
          end else begin
            body_hit = 1'b1;
            body_res = mk_error(ERR_ESC_SYNTAX, esc_pos);
            err_next = 1'b1;
          end
        end
        PH_ESC_TO: begin
          if (hx.ok) begin
            if (esc_to[CODE_BITS-1 -: 4] != 4'd0) ovf_next = 1'b1;
            to_next    = {esc_to[CODE_BITS-5:0], hx.val};
            digit_next = 1'b1;
          end else if (byte_q == CH_DASH) begin
            body_hit = 1'b1;
            body_res = mk_error(ERR_ESC_SYNTAX, esc_pos);
            err_next = 1'b1;
          end else if (!digit_seen || ovf) begin
            body_hit = 1'b1;
            body_res = mk_error(ERR_ESC_SYNTAX, esc_pos);
            err_next = 1'b1;
          end else begin
            body_hit   = (esc_from <= esc_to);
            body_res   = mk_range(esc_from, esc_to);
            held_next  = byte_q;
            phase_next = PH_HELD;
          end
        end
        default: begin
          held_next  = byte_q;
          phase_next = PH_HELD;
        end
      endcase
    end
  end

  // Flush of whatever is pending when the last byte of the spec arrives
  always_comb begin
    fin_hit = 1'b0;
    fin_res = '0;
    if (!err_next) begin
      unique case (phase_next) inside
        PH_HELD: begin
          fin_hit = 1'b1;
          fin_res = mk_range(CODE_BITS'(held_next), CODE_BITS'(held_next));
        end
        PH_DASH: begin
          fin_hit = 1'b1;
          fin_res = mk_error(ERR_NO_UPPER, pos_inc);
        end
        PH_ESC_FROM, PH_ESC_BSL, PH_ESC_U: begin
          fin_hit = 1'b1;
          fin_res = mk_error(ERR_ESC_SYNTAX, epos_next);
        end
        PH_ESC_TO: begin
          if (close_fail) begin
            fin_hit = 1'b1;
            fin_res = mk_error(ERR_ESC_SYNTAX, epos_next);
          end else if (close_emit) begin
            fin_hit = 1'b1;
            fin_res = mk_range(from_next, to_next);
          end
        end
        default: begin
          fin_hit = 1'b0;
        end
      endcase
    end
  end

  always_comb begin
    push = '0;
    if (advance) begin
      if (body_hit) begin
        push.first = body_res;
        push.count = 2'd1;
        if (fin_q) begin
          if (fin_hit) begin
            push.second           = fin_res;
            push.second.spec_done = 1'b1;
            push.count            = 2'd2;
          end else begin
            push.first.spec_done = 1'b1;
          end
        end
      end else if (fin_q) begin
        push.first           = fin_hit ? fin_res : '0;
        push.first.spec_done = 1'b1;
        push.count           = 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      byte_q <= spec_byte;
      fin_q  <= final_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full    <= 1'b0;
      phase      <= PH_IDLE;
      held       <= '0;
      esc_from   <= '0;
      esc_to     <= '0;
      ovf        <= 1'b0;
      digit_seen <= 1'b0;
      esc_pos    <= '0;
      pos        <= '0;
      err        <= 1'b0;
    end else begin
      if (in_valid && !in_stall) in_full <= 1'b1;
      else if (advance) in_full <= 1'b0;

      if (advance) begin
        if (fin_q) begin
          // drop all parse state: next word starts a new spec
          phase      <= PH_IDLE;
          held       <= '0;
          esc_from   <= '0;
          esc_to     <= '0;
          ovf        <= 1'b0;
          digit_seen <= 1'b0;
          esc_pos    <= '0;
          pos        <= '0;
          err        <= 1'b0;
        end else begin
          phase      <= phase_next;
          held       <= held_next;
          esc_from   <= from_next;
          esc_to     <= to_next;
          ovf        <= ovf_next;
          digit_seen <= digit_next;
          esc_pos    <= epos_next;
          pos        <= pos_inc;
          err        <= err_next;
        end
      end
    end
  end

`ifndef SYNTHESIS
  a_final_marks_done: assert property (@(posedge clk) disable iff (rst)
    advance && fin_q |->
      (push.count == 2'd1 && push.first.spec_done) ||
      (push.count == 2'd2 && push.second.spec_done && !push.first.spec_done))
    else $error("final word did not close the spec with a done result");

  a_final_clears: assert property (@(posedge clk) disable iff (rst)
    advance && fin_q |=> pos == '0 && !err && phase == PH_IDLE)
    else $error("parse state not cleared after final word");
`endif

endmodule

[src/csrp_result_queue.sv]
// Four-entry result queue: takes up to two results per cycle while it signals room, delivers one per handshake.
// Depends on csrp_pkg; sits between csrp_parser and the output channel.
`timescale 1ns / 1ps

module csrp_result_queue import csrp_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  push_t   push,
  output logic    room,
  output logic    out_valid,
  input  logic    out_stall,
  output result_t out_word
);

  result_t        mem [QDEPTH];
  logic [QAW-1:0] wr_ptr;
  logic [QAW-1:0] rd_ptr;
  logic [QAW:0]   count;
  logic           pop;

  assign out_valid = count != '0;
  assign out_word  = mem[rd_ptr];
  assign pop       = out_valid && !out_stall;
  // Leave space for a two-result word regardless of this cycle's pop
  assign room      = count <= (QAW+1)'(QDEPTH - 2);

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) mem[wr_ptr] <= push.first;
    if (push.count == 2'd2) mem[wr_ptr + QAW'(1)] <= push.second;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + QAW'(push.count);
      if (pop) rd_ptr <= rd_ptr + QAW'(1);
      count <= count + (QAW+1)'(push.count) - (QAW+1)'(pop);
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push.count != 2'd0 |-> (int'(count) + int'(push.count)) <= QDEPTH)
    else $error("result queue overflow");
`endif

endmodule
